### rtl/nep_pkg.sv
// Shared types, codes, constants, helper functions and the step program for the projection unit.
`default_nettype none

package nep_pkg;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV,
    OP_MD,   // multiply in forward mode, divide in inverse mode
    OP_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] dst;
    logic [5:0] sa;
    logic [5:0] sb;
  } step_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } exec_req_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_FETCH,
    SQ_ISSUE,
    SQ_WAIT,
    SQ_DISPATCH,
    SQ_OUT
  } seq_state_e;

  typedef enum logic [2:0] {
    SEG_FWD,
    SEG_INV,
    SEG_ITER,
    SEG_XPOLY,
    SEG_YB
  } seg_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_RUN
  } div_state_e;

  localparam int PC_W = 6;

  // configuration register indexes
  localparam logic CFG_ITER_LIMIT = 1'b0;
  localparam logic CFG_STEP_TOL   = 1'b1;

  // scratch registers (also usable as operand codes)
  localparam logic [5:0] R_YC  = 6'd0;
  localparam logic [5:0] R_P2  = 6'd1;
  localparam logic [5:0] R_P4  = 6'd2;
  localparam logic [5:0] R_P6  = 6'd3;
  localparam logic [5:0] R_P8  = 6'd4;
  localparam logic [5:0] R_P12 = 6'd5;
  localparam logic [5:0] R_S   = 6'd6;
  localparam logic [5:0] R_T   = 6'd7;
  localparam logic [5:0] R_F   = 6'd8;
  localparam logic [5:0] R_FD  = 6'd9;
  localparam logic [5:0] R_ST  = 6'd10;
  localparam logic [5:0] D_R1  = 6'd14;
  localparam logic [5:0] D_R2  = 6'd15;

  // fixed operand sources
  localparam logic [5:0] SRC_C1   = 6'd16;
  localparam logic [5:0] SRC_C2   = 6'd17;
  localparam logic [5:0] SRC_Y    = 6'd18;
  localparam logic [5:0] SRC_ZERO = 6'd19;
  localparam logic [5:0] SRC_A0   = 6'd20;
  localparam logic [5:0] SRC_A1   = 6'd21;
  localparam logic [5:0] SRC_A2   = 6'd22;
  localparam logic [5:0] SRC_A3   = 6'd23;
  localparam logic [5:0] SRC_A4   = 6'd24;
  localparam logic [5:0] SRC_A5   = 6'd25;
  localparam logic [5:0] SRC_B0   = 6'd26;
  localparam logic [5:0] SRC_B1   = 6'd27;
  localparam logic [5:0] SRC_B2   = 6'd28;
  localparam logic [5:0] SRC_B3   = 6'd29;
  localparam logic [5:0] SRC_K1   = 6'd30;
  localparam logic [5:0] SRC_K2   = 6'd31;
  localparam logic [5:0] SRC_K3   = 6'd32;

  // program entry points
  localparam logic [PC_W-1:0] L_FWD   = 6'd0;
  localparam logic [PC_W-1:0] L_INV   = 6'd2;
  localparam logic [PC_W-1:0] L_XPOLY = 6'd4;
  localparam logic [PC_W-1:0] L_YB    = 6'd20;
  localparam logic [PC_W-1:0] L_ITER  = 6'd29;

  // polynomial coefficients in Q24.40
  localparam logic signed [63:0] K40_A0   =  64'sd931495255936;
  localparam logic signed [63:0] K40_A1   = -64'sd143629203936;
  localparam logic signed [63:0] K40_A2   = -64'sd49642949994;
  localparam logic signed [63:0] K40_A3   =  64'sd60407168830;
  localparam logic signed [63:0] K40_A4   = -64'sd25574640462;
  localparam logic signed [63:0] K40_A5   =  64'sd3639383488;
  localparam logic signed [63:0] K40_B0   =  64'sd1112518850333;
  localparam logic signed [63:0] K40_B1   = -64'sd28862180229;
  localparam logic signed [63:0] K40_B2   =  64'sd21176593951;
  localparam logic signed [63:0] K40_B3   = -64'sd4354066046;
  localparam logic signed [63:0] K40_C1   = -64'sd259759622062;
  localparam logic signed [63:0] K40_C2   =  64'sd232942533461;
  localparam logic signed [63:0] K40_C3   = -64'sd56602858598;
  localparam logic signed [63:0] K40_MAXY =  64'sd1565956531663;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    logic [63:0] r;
    r = a[63] ? (64'd0 - a) : a;
    return r;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    logic signed [63:0] r;
    if (neg) begin
      r = m[63] ? 64'sh8000_0000_0000_0000 : (64'sd0 - $signed(m));
    end else begin
      r = m[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(m);
    end
    return r;
  endfunction

  function automatic logic signed [63:0] cst(input logic signed [63:0] c40, input int frac);
    int          s;
    logic [63:0] m;
    s = 40 - frac;
    if (s == 0) begin
      return c40;
    end
    m = (mag(c40) + (64'd1 << (s - 1))) >> s;
    return from_mag(c40[63], m);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic step_t mk(input op_e op, input logic [5:0] dst,
                               input logic [5:0] sa, input logic [5:0] sb);
    step_t s;
    s.op  = op;
    s.dst = dst[3:0];
    s.sa  = sa;
    s.sb  = sb;
    return s;
  endfunction

  function automatic step_t prog(input logic [PC_W-1:0] pc);
    step_t s;
    case (pc)
      // forward entry: working latitude is the input latitude
      6'd0:  s = mk(OP_ADD, R_YC, SRC_C2, SRC_ZERO);
      6'd1:  s = mk(OP_END, R_YC, SRC_ZERO, SRC_ZERO);
      // inverse entry: start from the clamped y
      6'd2:  s = mk(OP_ADD, R_YC, SRC_Y, SRC_ZERO);
      6'd3:  s = mk(OP_END, R_YC, SRC_ZERO, SRC_ZERO);
      // x polynomial at YC, then first result
      6'd4:  s = mk(OP_MUL, R_P2, R_YC, R_YC);
      6'd5:  s = mk(OP_MUL, R_P4, R_P2, R_P2);
      6'd6:  s = mk(OP_MUL, R_P6, R_P2, R_P4);
      6'd7:  s = mk(OP_MUL, R_P12, R_P6, R_P6);
      6'd8:  s = mk(OP_MUL, R_S, SRC_A3, R_P2);
      6'd9:  s = mk(OP_ADD, R_S, SRC_A2, R_S);
      6'd10: s = mk(OP_MUL, R_T, SRC_A4, R_P4);
      6'd11: s = mk(OP_ADD, R_S, R_S, R_T);
      6'd12: s = mk(OP_MUL, R_T, SRC_A5, R_P6);
      6'd13: s = mk(OP_ADD, R_S, R_S, R_T);
      6'd14: s = mk(OP_MUL, R_T, R_P12, R_S);
      6'd15: s = mk(OP_MUL, R_S, SRC_A1, R_P2);
      6'd16: s = mk(OP_ADD, R_S, SRC_A0, R_S);
      6'd17: s = mk(OP_ADD, R_S, R_S, R_T);
      6'd18: s = mk(OP_MD, D_R1, SRC_C1, R_S);
      6'd19: s = mk(OP_END, R_YC, SRC_ZERO, SRC_ZERO);
      // forward y polynomial, reuses P2 and P4
      6'd20: s = mk(OP_MUL, R_P8, R_P4, R_P4);
      6'd21: s = mk(OP_MUL, R_S, SRC_B2, R_P2);
      6'd22: s = mk(OP_ADD, R_S, SRC_B1, R_S);
      6'd23: s = mk(OP_MUL, R_T, SRC_B3, R_P4);
      6'd24: s = mk(OP_ADD, R_S, R_S, R_T);
      6'd25: s = mk(OP_MUL, R_T, R_P8, R_S);
      6'd26: s = mk(OP_ADD, R_S, SRC_B0, R_T);
      6'd27: s = mk(OP_MUL, D_R2, R_YC, R_S);
      6'd28: s = mk(OP_END, R_YC, SRC_ZERO, SRC_ZERO);
      // one Newton step
      6'd29: s = mk(OP_MUL, R_P2, R_YC, R_YC);
      6'd30: s = mk(OP_MUL, R_P4, R_P2, R_P2);
      6'd31: s = mk(OP_MUL, R_P8, R_P4, R_P4);
      6'd32: s = mk(OP_MUL, R_S, SRC_B2, R_P2);
      6'd33: s = mk(OP_ADD, R_S, SRC_B1, R_S);
      6'd34: s = mk(OP_MUL, R_T, SRC_B3, R_P4);
      6'd35: s = mk(OP_ADD, R_S, R_S, R_T);
      6'd36: s = mk(OP_MUL, R_T, R_P8, R_S);
      6'd37: s = mk(OP_ADD, R_S, SRC_B0, R_T);
      6'd38: s = mk(OP_MUL, R_T, R_YC, R_S);
      6'd39: s = mk(OP_SUB, R_F, R_T, SRC_Y);
      6'd40: s = mk(OP_MUL, R_S, SRC_K2, R_P2);
      6'd41: s = mk(OP_ADD, R_S, SRC_K1, R_S);
      6'd42: s = mk(OP_MUL, R_T, SRC_K3, R_P4);
      6'd43: s = mk(OP_ADD, R_S, R_S, R_T);
      6'd44: s = mk(OP_MUL, R_T, R_P8, R_S);
      6'd45: s = mk(OP_ADD, R_FD, SRC_B0, R_T);
      6'd46: s = mk(OP_DIV, R_ST, R_F, R_FD);
      6'd47: s = mk(OP_SUB, R_YC, R_YC, R_ST);
      default: s = mk(OP_END, R_YC, SRC_ZERO, SRC_ZERO);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/nep_mul.sv
// Multi-cycle rounded, saturating fixed-point multiplier on one 32x32 multiplier.
`default_nettype none

module nep_mul #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  output logic                    done_o,
  output logic signed [63:0]      y_o
);
  import nep_pkg::*;

  localparam logic [128:0] RND = 129'd1 << (FRAC_BITS - 1);

  logic               busy_q;
  logic [2:0]         cnt_q;
  logic               done_q;
  logic [63:0]        ma_q, mb_q;
  logic               neg_q;
  logic [127:0]       acc_q;
  logic signed [63:0] y_q;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [128:0] full;
  logic [63:0]  res;

  // partial product k: a half k[1] times b half k[0]
  always_comb begin
    pa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    pb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    case ({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      2'd2:    pp_sh = {pp, 64'd0};
      default: pp_sh = '0;
    endcase
    full = {1'b0, acc_q} + RND;
    res  = (|full[128:64+FRAC_BITS]) ? '1 : full[63+FRAC_BITS:FRAC_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= mag(a_i);
      mb_q  <= mag(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == 3'd4) begin
        y_q <= from_mag(neg_q, res);
      end else begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

`default_nettype wire

### rtl/nep_div.sv
// Bit-serial rounded, saturating fixed-point divider, one quotient bit per cycle.
`default_nettype none

module nep_div #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  output logic                    done_o,
  output logic signed [63:0]      y_o
);
  import nep_pkg::*;

  div_state_e         state_q;
  logic [5:0]         cnt_q;
  logic               done_q;
  logic [63:0]        ma_q, mb_q, q_q;
  logic               neg_q, aneg_q;
  logic [127:0]       n_q;
  logic signed [63:0] y_q;

  logic [127:0] num;
  logic [64:0]  t;
  logic         ge;
  logic [64:0]  t_sub;
  logic [63:0]  q_nx;

  always_comb begin
    // numerator scaled by 2^F plus half the divisor for rounding
    num   = ({64'd0, ma_q} << FRAC_BITS) + {65'd0, mb_q[63:1]};
    t     = n_q[127:63];
    ge    = t >= {1'b0, mb_q};
    t_sub = t - {1'b0, mb_q};
    q_nx  = {q_q[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            state_q <= DV_PREP;
          end
        end
        DV_PREP: begin
          if (mb_q == '0 || num[127:64] >= mb_q) begin
            state_q <= DV_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= DV_RUN;
            cnt_q   <= '0;
          end
        end
        DV_RUN: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= DV_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          ma_q   <= mag(a_i);
          mb_q   <= mag(b_i);
          neg_q  <= a_i[63] ^ b_i[63];
          aneg_q <= a_i[63];
        end
      end
      DV_PREP: begin
        q_q <= '0;
        n_q <= num;
        if (mb_q == '0) begin
          y_q <= (ma_q == '0) ? 64'sd0 : from_mag(aneg_q, '1);
        end else if (num[127:64] >= mb_q) begin
          y_q <= from_mag(neg_q, '1);
        end
      end
      DV_RUN: begin
        n_q <= {(ge ? t_sub[63:0] : t[63:0]), n_q[62:0], 1'b0};
        q_q <= q_nx;
        if (cnt_q == 6'd63) begin
          y_q <= from_mag(neg_q, q_nx);
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

`default_nettype wire

### rtl/nep_exec.sv
// Shared execution unit: saturating add/subtract, multiplier and divider behind one request.
`default_nettype none

module nep_exec #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire nep_pkg::exec_req_t        req_i,
  input  wire logic signed [63:0]        a_i,
  input  wire logic signed [63:0]        b_i,
  output logic                           done_o,
  output logic signed [63:0]             y_o
);
  import nep_pkg::*;

  logic               mul_done, div_done;
  logic signed [63:0] mul_y, div_y;
  logic               as_done_q;
  logic signed [63:0] as_y_q;
  logic [64:0]        sum;
  logic signed [63:0] as_y;

  nep_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(req_i.start && req_i.op == OP_MUL),
    .a_i    (a_i),
    .b_i    (b_i),
    .done_o (mul_done),
    .y_o    (mul_y)
  );

  nep_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(req_i.start && req_i.op == OP_DIV),
    .a_i    (a_i),
    .b_i    (b_i),
    .done_o (div_done),
    .y_o    (div_y)
  );

  always_comb begin
    if (req_i.op == OP_SUB) begin
      sum = {a_i[63], a_i} - {b_i[63], b_i};
    end else begin
      sum = {a_i[63], a_i} + {b_i[63], b_i};
    end
    if (sum[64] != sum[63]) begin
      as_y = sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      as_y = $signed(sum[63:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      as_done_q <= 1'b0;
    end else begin
      as_done_q <= req_i.start && (req_i.op == OP_ADD || req_i.op == OP_SUB);
    end
  end

  always_ff @(posedge clk_i) begin
    as_y_q <= as_y;
  end

  assign done_o = mul_done | div_done | as_done_q;
  assign y_o    = mul_done ? mul_y : (div_done ? div_y : as_y_q);

endmodule

`default_nettype wire

### rtl/natural_earth2_projection.sv
// Natural Earth II projection, forward and inverse, Q(32-F).F fixed point.
// Input channel (in_valid_i/in_ready_o): operation, first and second coordinate.
// Output channel (out_valid_o/out_ready_i): first and second result, not_converged.
// Config port: cfg_we_i writes cfg_wdata_i into iteration limit (index 0) or step
// tolerance (index 1) with no handshake; write only while the block is idle.
// One item at a time: a small sequencer steps through a program that drives one
// shared execution unit; each step passes through a fetch and an issue state and
// then waits for the multiply, the add/subtract or the bit-serial divide to finish.
// Inverse runs Newton iterations first, so the iteration count sets its latency.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls, the finished next result holds in the sequencer until
// the output register frees up.
// Reset: iteration limit 100, step tolerance 1, no item in flight, output empty.
`default_nettype none

module natural_earth2_projection #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               operation_i,
  input  wire logic signed [31:0] first_coord_i,
  input  wire logic signed [31:0] second_coord_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      first_result_o,
  output logic signed [31:0]      second_result_o,
  output logic                    not_converged_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [7:0]         cfg_wdata_i
);
  import nep_pkg::*;

  localparam logic signed [63:0] KA0  = cst(K40_A0, FRAC_BITS);
  localparam logic signed [63:0] KA1  = cst(K40_A1, FRAC_BITS);
  localparam logic signed [63:0] KA2  = cst(K40_A2, FRAC_BITS);
  localparam logic signed [63:0] KA3  = cst(K40_A3, FRAC_BITS);
  localparam logic signed [63:0] KA4  = cst(K40_A4, FRAC_BITS);
  localparam logic signed [63:0] KA5  = cst(K40_A5, FRAC_BITS);
  localparam logic signed [63:0] KB0  = cst(K40_B0, FRAC_BITS);
  localparam logic signed [63:0] KB1  = cst(K40_B1, FRAC_BITS);
  localparam logic signed [63:0] KB2  = cst(K40_B2, FRAC_BITS);
  localparam logic signed [63:0] KB3  = cst(K40_B3, FRAC_BITS);
  localparam logic signed [63:0] KC1  = cst(K40_C1, FRAC_BITS);
  localparam logic signed [63:0] KC2  = cst(K40_C2, FRAC_BITS);
  localparam logic signed [63:0] KC3  = cst(K40_C3, FRAC_BITS);
  localparam logic signed [63:0] KMAXY = cst(K40_MAXY, FRAC_BITS);

  function automatic logic signed [63:0] src_val(
    input logic [5:0] sel, input logic signed [63:0] rd,
    input logic signed [63:0] c1, input logic signed [63:0] c2,
    input logic signed [63:0] y
  );
    logic signed [63:0] r;
    if (sel < SRC_C1) begin
      r = rd;
    end else begin
      case (sel)
        SRC_C1:  r = c1;
        SRC_C2:  r = c2;
        SRC_Y:   r = y;
        SRC_A0:  r = KA0;
        SRC_A1:  r = KA1;
        SRC_A2:  r = KA2;
        SRC_A3:  r = KA3;
        SRC_A4:  r = KA4;
        SRC_A5:  r = KA5;
        SRC_B0:  r = KB0;
        SRC_B1:  r = KB1;
        SRC_B2:  r = KB2;
        SRC_B3:  r = KB3;
        SRC_K1:  r = KC1;
        SRC_K2:  r = KC2;
        SRC_K3:  r = KC3;
        default: r = 64'sd0;
      endcase
    end
    return r;
  endfunction

  seq_state_e         state_q, state_d;
  seg_e               seg_q, seg_d;
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [7:0]         cnt_q, cnt_d;
  logic               flag_q, flag_d;
  logic               inv_q;
  logic [7:0]         limit_q, tol_q;
  logic               st_small_q;
  logic               out_valid_q;
  logic [31:0]        out1_q, out2_q;
  logic               outf_q;
  logic [31:0]        res1_q, res2_q;
  logic signed [63:0] c1_q, c2_q, y_q;
  logic signed [63:0] rd_a_q, rd_b_q;
  logic signed [63:0] rf_mem [16];

  step_t              step;
  exec_req_t          ex_req;
  logic               ex_done;
  logic signed [63:0] ex_y;
  logic signed [63:0] opa, opb;
  logic signed [63:0] c2_ext;
  logic signed [63:0] y_clamp;
  logic               accept;
  logic               wb;
  logic               out_load;

  assign step     = prog(pc_q);
  assign accept   = in_valid_i && in_ready_o;
  assign wb       = (state_q == SQ_WAIT) && ex_done;
  assign out_load = (state_q == SQ_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    c2_ext = {{32{second_coord_i[31]}}, second_coord_i};
    if (c2_ext > KMAXY) begin
      y_clamp = KMAXY;
    end else if (c2_ext < -KMAXY) begin
      y_clamp = -KMAXY;
    end else begin
      y_clamp = c2_ext;
    end
    opa = src_val(step.sa, rd_a_q, c1_q, c2_q, y_q);
    opb = src_val(step.sb, rd_b_q, c1_q, c2_q, y_q);
    ex_req.start = (state_q == SQ_ISSUE);
    if (step.op == OP_MD) begin
      ex_req.op = inv_q ? OP_DIV : OP_MUL;
    end else begin
      ex_req.op = step.op;
    end
  end

  nep_exec #(.FRAC_BITS(FRAC_BITS)) u_exec (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ex_req),
    .a_i   (opa),
    .b_i   (opb),
    .done_o(ex_done),
    .y_o   (ex_y)
  );

  // sequencer: next state, program counter and segment dispatch
  always_comb begin
    state_d    = state_q;
    seg_d      = seg_q;
    pc_d       = pc_q;
    cnt_d      = cnt_q;
    flag_d     = flag_q;
    in_ready_o = (state_q == SQ_IDLE);
    case (state_q)
      SQ_IDLE: begin
        if (in_valid_i) begin
          state_d = SQ_FETCH;
          pc_d    = operation_i ? L_INV : L_FWD;
          seg_d   = operation_i ? SEG_INV : SEG_FWD;
          cnt_d   = '0;
          flag_d  = 1'b0;
        end
      end
      SQ_FETCH: state_d = (step.op == OP_END) ? SQ_DISPATCH : SQ_ISSUE;
      SQ_ISSUE: state_d = SQ_WAIT;
      SQ_WAIT: begin
        if (ex_done) begin
          state_d = SQ_FETCH;
          pc_d    = pc_q + 6'd1;
        end
      end
      SQ_DISPATCH: begin
        state_d = SQ_FETCH;
        case (seg_q)
          SEG_FWD: begin
            seg_d = SEG_XPOLY;
            pc_d  = L_XPOLY;
          end
          SEG_INV: begin
            if (limit_q == '0) begin
              flag_d = 1'b1;
              seg_d  = SEG_XPOLY;
              pc_d   = L_XPOLY;
            end else begin
              seg_d = SEG_ITER;
              pc_d  = L_ITER;
            end
          end
          SEG_ITER: begin
            if (st_small_q) begin
              flag_d = 1'b0;
              seg_d  = SEG_XPOLY;
              pc_d   = L_XPOLY;
            end else if (cnt_q + 8'd1 == limit_q) begin
              flag_d = 1'b1;
              seg_d  = SEG_XPOLY;
              pc_d   = L_XPOLY;
            end else begin
              cnt_d = cnt_q + 8'd1;
              pc_d  = L_ITER;
            end
          end
          SEG_XPOLY: begin
            if (inv_q) begin
              state_d = SQ_OUT;
            end else begin
              seg_d = SEG_YB;
              pc_d  = L_YB;
            end
          end
          SEG_YB:  state_d = SQ_OUT;
          default: state_d = SQ_IDLE;
        endcase
      end
      SQ_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      seg_q       <= SEG_FWD;
      pc_q        <= L_FWD;
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      inv_q       <= 1'b0;
      st_small_q  <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= 8'd100;
      tol_q       <= 8'd1;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      flag_q  <= flag_d;
      if (accept) begin
        inv_q <= operation_i;
      end
      if (wb && step.dst == R_ST[3:0]) begin
        st_small_q <= mag(ex_y) <= {56'd0, tol_q};
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ITER_LIMIT: limit_q <= cfg_wdata_i;
          CFG_STEP_TOL:   tol_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // operands and scratch registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c1_q <= {{32{first_coord_i[31]}}, first_coord_i};
      c2_q <= c2_ext;
      y_q  <= y_clamp;
    end
    if (wb) begin
      rf_mem[step.dst] <= ex_y;
      if (step.dst == D_R1[3:0]) begin
        res1_q <= sat32(ex_y);
      end
      if (step.dst == D_R2[3:0] || (inv_q && step.dst == R_YC[3:0])) begin
        res2_q <= sat32(ex_y);
      end
    end
    rd_a_q <= rf_mem[step.sa[3:0]];
    rd_b_q <= rf_mem[step.sb[3:0]];
    if (out_load) begin
      out1_q <= res1_q;
      out2_q <= res2_q;
      outf_q <= flag_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign first_result_o  = out1_q;
  assign second_result_o = out2_q;
  assign not_converged_o = outf_q;

endmodule

`default_nettype wire
